[sv/bounded_list_engine_unit_assert.svh]
// Assertion macros used by the checker file of the list engine
`ifndef BOUNDED_LIST_ENGINE_UNIT_ASSERT_SVH
`define BOUNDED_LIST_ENGINE_UNIT_ASSERT_SVH

// clocked property, switched off while reset is low
`define BLU_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked property that also holds during reset
`define BLU_ASSERT_NORST(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/blu_pkg.sv]
// Types, codes and field layout of the bounded list engine
package blu_pkg;

	localparam int unsigned DEPTH_DEF = 128;

	localparam int unsigned ACT_W  = 3;
	localparam int unsigned POS_W  = 7;
	localparam int unsigned VAL_W  = 32;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned LEN_W  = 8;

	// input item layout
	localparam int unsigned IN_ACT_LO   = 0;
	localparam int unsigned IN_POS_LO   = IN_ACT_LO + ACT_W;
	localparam int unsigned IN_VAL_LO   = IN_POS_LO + POS_W;
	localparam int unsigned IN_FIELDS_W = IN_VAL_LO + VAL_W;
	localparam int unsigned IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

	// result item layout
	localparam int unsigned OUT_STAT_LO  = 0;
	localparam int unsigned OUT_POP_LO   = OUT_STAT_LO + STAT_W;
	localparam int unsigned OUT_LEN_LO   = OUT_POP_LO + VAL_W;
	localparam int unsigned OUT_TOT_LO   = OUT_LEN_LO + LEN_W;
	localparam int unsigned OUT_FIELDS_W = OUT_TOT_LO + VAL_W;
	localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH   = 3'd0,
		ACT_POP    = 3'd1,
		ACT_ERASE  = 3'd2,
		ACT_INSERT = 3'd3,
		ACT_CLEAR  = 3'd4,
		ACT_QUERY  = 3'd5
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_SHIFT = 2'd1,
		S_DRAIN = 2'd2,
		S_FIN   = 2'd3
	} fsm_t;

endpackage

[sv/blu_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data
module blu_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[sv/bounded_list_engine_unit.sv]
// Push, clear, query, refused actions and an insert at the tail go from accept straight to
// the result state. Pop reads one slot, erase and insert n = length - position slots; all
// then pass the drain state to the result state. One item at a time: the next item is taken
// only once the result state has handed its result on, and the element shift loop through
// the single read port makes the longest items. Reset (arst_n low) empties the list and
// clears the sum; slot contents are kept, since no slot at or above the fill count is ever read.
module bounded_list_engine_unit import blu_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // action, position, value, zero pad
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // status, popped, length_now, total, zero pad
);

	localparam int unsigned AW   = $clog2(DEPTH);
	localparam int unsigned CW   = $clog2(DEPTH + 1);
	localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

	fsm_t             state_q, state_d;
	action_t          act_q;
	status_t          status_q;
	logic [AW-1:0]    pos_q;
	logic [VAL_W-1:0] val_q;
	logic [CW-1:0]    fill_q;
	logic [VAL_W-1:0] total_q;
	logic [VAL_W-1:0] removed_q;
	logic [AW-1:0]    cur_q;
	logic [CW-1:0]    rem_q;
	logic             m_tvalid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic             rd_vld_s1;
	logic             rd_first_s1;
	logic [AW-1:0]    rd_addr_s1;

	// incoming item
	action_t          in_act;
	logic [POS_W-1:0] in_pos;
	logic [VAL_W-1:0] in_val;
	status_t          in_status;
	logic [CW-1:0]    in_rem;
	logic [AW-1:0]    in_start;
	logic [AW-1:0]    in_anchor;
	logic             full, empty, accept, out_free, fin_go;
	logic [CW-1:0]    fill_m1;

	// RAM ports
	logic             ram_rd_en, ram_wr_en;
	logic [AW-1:0]    ram_rd_addr, ram_wr_addr;
	logic [VAL_W-1:0] ram_wr_data, ram_rd_data;

	// commit values
	logic [CW-1:0]    fill_n;
	logic [VAL_W-1:0] total_n, popped_n;

	assign in_act = action_t'(s_tdata[IN_POS_LO-1:IN_ACT_LO]);
	assign in_pos = s_tdata[IN_VAL_LO-1:IN_POS_LO];
	assign in_val = s_tdata[IN_FIELDS_W-1:IN_VAL_LO];

	assign full     = (fill_q == CW'(DEPTH));
	assign empty    = (fill_q == '0);
	assign fill_m1  = fill_q - CW'(1);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign fin_go   = (state_q == S_FIN) && out_free;

	always_comb begin
		in_status = ST_OK;
		in_rem    = '0;
		in_start  = AW'(in_pos);
		in_anchor = AW'(in_pos);
		case (in_act)
			ACT_PUSH: begin
				if (full) in_status = ST_FULL;
			end
			ACT_POP: begin
				if (empty) in_status = ST_EMPTY;
				in_rem    = CW'(1);
				in_start  = AW'(fill_m1);
				in_anchor = AW'(fill_m1);
			end
			ACT_ERASE: begin
				if (CMPW'(in_pos) >= CMPW'(fill_q)) in_status = ST_RANGE;
				in_rem = fill_q - CW'(in_pos);
			end
			ACT_INSERT: begin
				if (CMPW'(in_pos) > CMPW'(fill_q)) in_status = ST_RANGE;
				else if (full) in_status = ST_FULL;
				in_rem   = fill_q - CW'(in_pos);
				in_start = AW'(fill_m1);
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (in_status == ST_OK && in_rem != '0) ? S_SHIFT : S_FIN;
				end
			end
			S_SHIFT: begin
				if (rem_q == CW'(1)) state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_FIN;
			S_FIN: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer: handshake and RAM ports
	always_comb begin
		s_tready    = 1'b0;
		ram_rd_en   = 1'b0;
		ram_rd_addr = cur_q;
		ram_wr_en   = 1'b0;
		ram_wr_addr = rd_addr_s1;
		ram_wr_data = ram_rd_data;
		case (state_q)
			S_IDLE: s_tready = 1'b1;
			S_SHIFT: ram_rd_en = 1'b1;
			S_FIN: begin
				if (out_free && status_q == ST_OK) begin
					if (act_q == ACT_PUSH) begin
						ram_wr_en   = 1'b1;
						ram_wr_addr = AW'(fill_q);
						ram_wr_data = val_q;
					end else if (act_q == ACT_INSERT) begin
						ram_wr_en   = 1'b1;
						ram_wr_addr = pos_q;
						ram_wr_data = val_q;
					end
				end
			end
			default: begin
			end
		endcase
		// shift write-back of the slot read in the previous cycle
		if (rd_vld_s1 && !rd_first_s1) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = (act_q == ACT_INSERT) ? rd_addr_s1 + AW'(1) : rd_addr_s1 - AW'(1);
			ram_wr_data = ram_rd_data;
		end
	end

	always_comb begin
		fill_n   = fill_q;
		total_n  = total_q;
		popped_n = '0;
		if (status_q == ST_OK) begin
			case (act_q)
				ACT_PUSH, ACT_INSERT: begin
					fill_n  = fill_q + CW'(1);
					total_n = total_q + val_q;
				end
				ACT_POP: begin
					fill_n   = fill_m1;
					total_n  = total_q - removed_q;
					popped_n = removed_q;
				end
				ACT_ERASE: begin
					fill_n  = fill_m1;
					total_n = total_q - removed_q;
				end
				ACT_CLEAR: begin
					fill_n  = '0;
					total_n = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fill_q     <= '0;
			total_q    <= '0;
			m_tvalid_q <= 1'b0;
			rd_vld_s1  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= ram_rd_en;
			if (fin_go) begin
				fill_q     <= fill_n;
				total_q    <= total_n;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= in_act;
			status_q <= in_status;
			pos_q    <= in_anchor;
			val_q    <= in_val;
			cur_q    <= in_start;
			rem_q    <= in_rem;
		end else if (state_q == S_SHIFT) begin
			cur_q <= (act_q == ACT_INSERT) ? cur_q - AW'(1) : cur_q + AW'(1);
			rem_q <= rem_q - CW'(1);
		end
		rd_addr_s1  <= cur_q;
		// the first slot an erase or pop reads is the one removed
		rd_first_s1 <= (cur_q == pos_q) && (act_q != ACT_INSERT);
		if (rd_vld_s1 && rd_first_s1) begin
			removed_q <= ram_rd_data;
		end
		if (fin_go) begin
			out_data_q <= {{OUT_PAD_W{1'b0}}, total_n, LEN_W'(fill_n), popped_n, status_q};
		end
	end

	blu_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_slots (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;

endmodule

[sv/blu_checker.sv]
// Port-level checker for the list engine, bound to the top level
`include "bounded_list_engine_unit_assert.svh"

module blu_checker import blu_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [IN_TDATA_W-1:0]  s_tdata,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	logic             s_acc;
	logic [VAL_W-1:0] popped;
	logic             refused;

	assign s_acc   = s_tvalid && s_tready && (s_tdata[IN_POS_LO-1:IN_ACT_LO] <= ACT_W'(7));
	assign popped  = m_tdata[OUT_LEN_LO-1:OUT_POP_LO];
	assign refused = (m_tdata[OUT_POP_LO-1:OUT_STAT_LO] != ST_OK);

	`BLU_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result item changed while stalled")
	`BLU_ASSERT(a_one_item, clk, arst_n, s_acc |=> !s_tready, "second item taken while one is at work")
	`BLU_ASSERT(a_refused_zero, clk, arst_n, m_tvalid && refused |-> popped == '0, "refused action reports a popped value")
	`BLU_ASSERT_NORST(a_rst_quiet, clk, !arst_n |-> !m_tvalid, "result valid during reset")

endmodule

bind bounded_list_engine_unit blu_checker u_blu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
